/* sv/etss_pkg.sv */
// Package: item types, character codes and scale constants for the elapsed-time parser.
`timescale 1ns / 1ps
`default_nettype none
package etss_pkg;

	// Width of the reported total
	localparam int TOTAL_BITS = 31;

	// Scale factors for the unit letters
	localparam int SCALE_DAY  = 86400;
	localparam int SCALE_HOUR = 3600;
	localparam int SCALE_MIN  = 60;
	localparam int SCALE_TEN  = 10;

	// Character codes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LC_D  = 8'h64;
	localparam logic [7:0] CH_UC_D  = 8'h44;
	localparam logic [7:0] CH_LC_H  = 8'h68;
	localparam logic [7:0] CH_UC_H  = 8'h48;
	localparam logic [7:0] CH_LC_M  = 8'h6d;
	localparam logic [7:0] CH_UC_M  = 8'h4d;
	localparam logic [7:0] CH_LC_S  = 8'h73;
	localparam logic [7:0] CH_UC_S  = 8'h53;

	// Parser phase
	typedef enum logic [1:0] {
		PH_START  = 2'd0,
		PH_SPACES = 2'd1,
		PH_DIGITS = 2'd2,
		PH_FAILED = 2'd3
	} phase_t;

	// Unit selected by a character
	typedef enum logic [2:0] {
		SC_NONE = 3'd0,
		SC_DAY  = 3'd1,
		SC_HOUR = 3'd2,
		SC_MIN  = 3'd3,
		SC_SEC  = 3'd4
	} scale_sel_t;

	// One input item
	typedef struct packed {
		logic [7:0] char_code;
		logic       terminator;
	} char_item_t;

	// One result item
	typedef struct packed {
		logic [TOTAL_BITS-1:0] total_seconds;
		logic                  ok;
		logic                  saturated;
	} result_item_t;

endpackage
`default_nettype wire

/* sv/etss_core.sv */
// Parser state machine: phase, current number, running total and clip flag.
`timescale 1ns / 1ps
`default_nettype none
module etss_core #(
	parameter int VALUE_BITS = 31
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   step,
	input  etss_pkg::char_item_t  item,
	output etss_pkg::result_item_t result
);
	import etss_pkg::*;

	localparam logic [VALUE_BITS-1:0] MAX_VAL  = '1;
	localparam logic [VALUE_BITS-1:0] LIM_TEN  = MAX_VAL / VALUE_BITS'(SCALE_TEN);
	localparam logic [VALUE_BITS-1:0] LIM_DAY  = MAX_VAL / VALUE_BITS'(SCALE_DAY);
	localparam logic [VALUE_BITS-1:0] LIM_HOUR = MAX_VAL / VALUE_BITS'(SCALE_HOUR);
	localparam logic [VALUE_BITS-1:0] LIM_MIN  = MAX_VAL / VALUE_BITS'(SCALE_MIN);

	phase_t                  phase_q, phase_d;
	logic [VALUE_BITS-1:0]   number_q, number_d;
	logic [VALUE_BITS-1:0]   total_q, total_d;
	logic                    clip_q, clip_d;

	logic                    is_digit;
	logic                    is_space;
	scale_sel_t              sel;
	scale_sel_t              sel_eff;
	logic [3:0]              digit;

	logic [VALUE_BITS-1:0]   num_ten;
	logic [VALUE_BITS:0]     num_sum;
	logic                    clip_digit;
	logic [VALUE_BITS-1:0]   num_next;

	logic [VALUE_BITS-1:0]   prod;
	logic [VALUE_BITS-1:0]   lim;
	logic                    clip_scale;
	logic [VALUE_BITS-1:0]   scaled;
	logic [VALUE_BITS:0]     tot_sum;
	logic                    clip_tot;
	logic [VALUE_BITS-1:0]   tot_next;

	logic                    good;
	logic [VALUE_BITS-1:0]   tot_out;
	logic [VALUE_BITS+TOTAL_BITS-1:0] tot_wide;

	// Classify the character
	always_comb begin
		is_space = (item.char_code == CH_SPACE);
		is_digit = 1'b0;
		sel      = SC_NONE;
		case (item.char_code) inside
			[CH_ZERO:CH_NINE]:          is_digit = 1'b1;
			CH_LC_D, CH_UC_D:           sel = SC_DAY;
			CH_LC_H, CH_UC_H:           sel = SC_HOUR;
			CH_LC_M, CH_UC_M:           sel = SC_MIN;
			CH_LC_S, CH_UC_S, CH_SPACE: sel = SC_SEC;
			default:                    sel = SC_NONE;
		endcase
		// low nibble of an ASCII digit is its value
		digit   = item.char_code[3:0];
		// a number that ends the string counts as seconds
		sel_eff = item.terminator ? SC_SEC : sel;
	end

	// Accumulate a digit: saturating number * 10 + digit
	always_comb begin
		num_ten    = (number_q << 3) + (number_q << 1);
		num_sum    = {1'b0, num_ten} + {{(VALUE_BITS-3){1'b0}}, digit};
		clip_digit = (number_q > LIM_TEN) || num_sum[VALUE_BITS];
		num_next   = clip_digit ? MAX_VAL : num_sum[VALUE_BITS-1:0];
	end

	// Scale the number and add it to the total, both saturating
	always_comb begin
		case (sel_eff)
			SC_DAY: begin
				prod = number_q * VALUE_BITS'(SCALE_DAY);
				lim  = LIM_DAY;
			end
			SC_HOUR: begin
				prod = number_q * VALUE_BITS'(SCALE_HOUR);
				lim  = LIM_HOUR;
			end
			SC_MIN: begin
				prod = number_q * VALUE_BITS'(SCALE_MIN);
				lim  = LIM_MIN;
			end
			default: begin
				prod = number_q;
				lim  = MAX_VAL;
			end
		endcase
		clip_scale = (number_q > lim);
		scaled     = clip_scale ? MAX_VAL : prod;
		tot_sum    = {1'b0, total_q} + {1'b0, scaled};
		clip_tot   = tot_sum[VALUE_BITS];
		tot_next   = clip_tot ? MAX_VAL : tot_sum[VALUE_BITS-1:0];
	end

	// Next state
	always_comb begin
		phase_d  = phase_q;
		number_d = number_q;
		total_d  = total_q;
		clip_d   = clip_q;
		if (step) begin
			if (item.terminator) begin
				phase_d  = PH_START;
				number_d = '0;
				total_d  = '0;
				clip_d   = 1'b0;
			end else begin
				case (phase_q)
					PH_START, PH_SPACES: begin
						if (is_space) begin
							phase_d = PH_SPACES;
						end else if (is_digit) begin
							number_d = {{(VALUE_BITS-4){1'b0}}, digit};
							phase_d  = PH_DIGITS;
						end else begin
							phase_d = PH_FAILED;
						end
					end
					PH_DIGITS: begin
						if (is_digit) begin
							number_d = num_next;
							clip_d   = clip_q | clip_digit;
						end else if (sel != SC_NONE) begin
							number_d = '0;
							total_d  = tot_next;
							clip_d   = clip_q | clip_scale | clip_tot;
							phase_d  = PH_START;
						end else begin
							phase_d = PH_FAILED;
						end
					end
					default: phase_d = PH_FAILED;
				endcase
			end
		end
	end

	// Result for a terminator
	always_comb begin
		good     = (phase_q == PH_START) || (phase_q == PH_DIGITS);
		tot_out  = (phase_q == PH_DIGITS) ? tot_next : total_q;
		tot_wide = {{TOTAL_BITS{1'b0}}, tot_out};
		result.total_seconds = good ? tot_wide[TOTAL_BITS-1:0] : '0;
		result.ok            = good;
		result.saturated     = good &&
			((phase_q == PH_DIGITS) ? (clip_q | clip_tot) : clip_q);
	end

	// Hold the parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			number_q <= '0;
			total_q  <= '0;
			clip_q   <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			number_q <= number_d;
			total_q  <= total_d;
			clip_q   <= clip_d;
		end
	end

endmodule
`default_nettype wire

/* sv/elapsed_time_string_to_seconds.sv */
// Top level: input register, parser core and result register.
//
// Usage: characters of an elapsed-time string such as "3d 2h 1m 10s" arrive
// on the char channel, one item each, closed by an item with terminator set.
// Each terminator gives one item on the result channel: total_seconds, ok and
// saturated. Other items give no result.
// Both channels use valid/stall; an item moves at a clock edge with valid high
// and stall low.
// Path: a terminator accepted into the input register passes through the parser
// core into the result register, from which its result can be taken.
// Throughput: one item per cycle while char_stall is low; the parser updates its number
// and total with a constant multiply and one saturating add per character.
// Stall: while a result waits under result_stall, character items keep
// flowing; only a second terminator held in the input register raises
// char_stall, until the waiting result is taken.
// Reset: arst_n clears both registers' valid flags and returns the parser to
// the start of a string with a zero total.
`timescale 1ns / 1ps
`default_nettype none
module elapsed_time_string_to_seconds #(
	parameter int VALUE_BITS = 31
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    char_valid,
	output logic                   char_stall,
	input  etss_pkg::char_item_t   char_item,
	output logic                   result_valid,
	input  wire                    result_stall,
	output etss_pkg::result_item_t result_item
);
	import etss_pkg::*;

	logic         valid_s1;
	char_item_t   item_s1;
	logic         advance;
	result_item_t core_result;
	logic         result_valid_q;
	result_item_t result_item_q;

	// Hold a terminator while the previous result is still waiting
	assign char_stall = valid_s1 && item_s1.terminator && result_valid_q && result_stall;
	assign advance    = valid_s1 && !char_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!char_stall && char_valid) begin
			item_s1 <= char_item;
		end
	end

	etss_core #(
		.VALUE_BITS(VALUE_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (core_result)
	);

	// Result register: load on a terminator, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && item_s1.terminator) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.terminator) begin
			result_item_q <= core_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result_item  = result_item_q;

endmodule
`default_nettype wire

/* sv/etss_checker.sv */
// Port checker for the elapsed-time parser and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module etss_checker (
	input wire                    clk,
	input wire                    arst_n,
	input wire                    char_valid,
	input wire                    char_stall,
	input etss_pkg::char_item_t   char_item,
	input wire                    result_valid,
	input wire                    result_stall,
	input etss_pkg::result_item_t result_item
);
	import etss_pkg::*;

	// A stalled result stays and holds its payload
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_item))
		else $error("result item changed under stall");

	// A failed string reports zero and no saturation
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_item.ok |->
			(result_item.total_seconds == '0) && !result_item.saturated)
		else $error("failed string with nonzero payload");

	// Input stall only while a result waits under stall
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> result_valid && result_stall)
		else $error("char_stall without a stalled result");

	// A fresh result follows a terminator accepted into the input register
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |->
			$past(char_valid && !char_stall && char_item.terminator, 2))
		else $error("result without a terminator");

endmodule

bind elapsed_time_string_to_seconds etss_checker u_etss_checker (.*);
`default_nettype wire
